// File: rtl/core/radix_digit_emitter_top_macros.svh
// ----------------------------------------------------------------------------
// radix digit emitter assertion macros
// concurrent assertion shorthands shared by the checker
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_TOP_MACROS_SVH
`define RADIX_DIGIT_EMITTER_TOP_MACROS_SVH

// overlapping implication, checked from reset release on
`define RDE_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("radix digit emitter assertion failed");

// implication checked in the cycle after the antecedent
`define RDE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("radix digit emitter assertion failed");

`endif

// File: rtl/core/rde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_pkg
// shared types, constants and the digit glyph lookup
// ----------------------------------------------------------------------------
package rde_pkg;

    localparam int DEFAULT_VALUE_BITS = 16;
    localparam int FIELD_BITS         = 16;
    localparam int RADIX_BITS         = 2;
    localparam int CHAR_BITS          = 7;
    localparam int DIGIT_BITS         = 4;
    localparam int TDATA_OUT_BITS     = 8;

    // radix select codes, unused code behaves as hex
    localparam logic [RADIX_BITS-1:0] RADIX_DEC   = 2'd0;
    localparam logic [RADIX_BITS-1:0] RADIX_OCT   = 2'd1;
    localparam logic [RADIX_BITS-1:0] RADIX_HEX   = 2'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_SPARE = 2'd3;

    // reciprocal of ten, exact for operands up to 16 bits
    localparam int                MAGIC_BITS = 17;
    localparam logic [MAGIC_BITS-1:0] DEC_MAGIC = 17'h0CCCD;
    localparam int                DEC_SHIFT  = 19;

    typedef struct packed {
        logic load;     // take a new number
        logic extract;  // peel off one digit, least significant first
        logic emit;     // move next stored digit to the output register
    } t_cmd;

    typedef struct packed {
        logic quot_zero; // quotient of this extract step is zero
        logic rd_last;   // digit about to be emitted is the final one
        logic out_free;  // output register can take a digit
    } t_status;

    function automatic logic [CHAR_BITS-1:0] digit_glyph(input logic [DIGIT_BITS-1:0] d);
        logic [CHAR_BITS-1:0] ext;
        ext = {{(CHAR_BITS-DIGIT_BITS){1'b0}}, d};
        if (d < 4'd10) begin
            return 7'h30 + ext;
        end else begin
            return 7'h37 + ext;
        end
    endfunction

endpackage

// File: rtl/core/rde_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_ctrl
// sequencer: accept, extract digits, emit digits
// ----------------------------------------------------------------------------
module rde_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  rde_pkg::t_status i_status,
    output rde_pkg::t_cmd    o_cmd
);
    import rde_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXTRACT,
        ST_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_req_ready   = (r_state == ST_IDLE);
        o_cmd.load    = (r_state == ST_IDLE) && i_req_valid;
        o_cmd.extract = (r_state == ST_EXTRACT);
        o_cmd.emit    = (r_state == ST_EMIT) && i_status.out_free;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_req_valid) n_state = ST_EXTRACT;
            end
            ST_EXTRACT: begin
                if (i_status.quot_zero) n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free && i_status.rd_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/core/rde_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_dp
// digit extraction, digit store and output register
// ----------------------------------------------------------------------------
module rde_dp #(
    parameter int VALUE_BITS = rde_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [rde_pkg::FIELD_BITS-1:0] i_value,
    input  logic [rde_pkg::RADIX_BITS-1:0] i_radix_sel,
    input  rde_pkg::t_cmd                  i_cmd,
    output rde_pkg::t_status               o_status,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [rde_pkg::CHAR_BITS-1:0]  o_out_char,
    output logic                           o_out_last
);
    import rde_pkg::*;

    localparam int EFF_BITS   = (VALUE_BITS < FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int MAX_DIGITS = (EFF_BITS + 2) / 3;
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int PROD_W     = EFF_BITS + DEC_SHIFT + 1;

    logic [EFF_BITS-1:0]   r_value;
    logic [RADIX_BITS-1:0] r_radix;
    logic [CNT_W-1:0]      r_wr_cnt;
    logic [CNT_W-1:0]      r_rd_idx;
    logic [DIGIT_BITS-1:0] r_buf [MAX_DIGITS];
    logic                  r_out_valid;
    logic [CHAR_BITS-1:0]  r_out_char;
    logic                  r_out_last;

    logic [PROD_W-1:0]     w_prod;
    logic [EFF_BITS-1:0]   w_q10;
    logic [EFF_BITS-1:0]   w_q10x;
    logic [EFF_BITS-1:0]   w_rem10;
    logic [EFF_BITS-1:0]   n_quot;
    logic [DIGIT_BITS-1:0] n_digit;

    // divide by the base: ten via the reciprocal, remainder by shift and add; eight or sixteen by shift
    always_comb begin
        w_prod  = PROD_W'(r_value) * PROD_W'(DEC_MAGIC);
        w_q10   = w_prod[DEC_SHIFT +: EFF_BITS];
        w_q10x  = (w_q10 << 3) + (w_q10 << 1);
        w_rem10 = r_value - w_q10x;
        unique case (r_radix)
            RADIX_DEC: begin
                n_quot  = w_q10;
                n_digit = w_rem10[DIGIT_BITS-1:0];
            end
            RADIX_OCT: begin
                n_quot  = r_value >> 3;
                n_digit = {1'b0, r_value[2:0]};
            end
            default: begin
                n_quot  = r_value >> 4;
                n_digit = r_value[DIGIT_BITS-1:0];
            end
        endcase
    end

    always_comb begin
        o_status.quot_zero = (n_quot == '0);
        o_status.rd_last   = (r_rd_idx == '0);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value[EFF_BITS-1:0];
            r_radix <= i_radix_sel;
        end else if (i_cmd.extract) begin
            r_value <= n_quot;
        end
        if (i_cmd.extract) begin
            r_buf[r_wr_cnt[IDX_W-1:0]] <= n_digit;
        end
        if (i_cmd.emit) begin
            r_out_char <= digit_glyph(r_buf[r_rd_idx[IDX_W-1:0]]);
            r_out_last <= (r_rd_idx == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_cnt    <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_wr_cnt <= '0;
            end else if (i_cmd.extract) begin
                r_wr_cnt <= r_wr_cnt + CNT_W'(1);
                r_rd_idx <= r_wr_cnt;
            end else if (i_cmd.emit) begin
                r_rd_idx <= r_rd_idx - CNT_W'(1);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

endmodule

// File: rtl/core/radix_digit_emitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_top
// unsigned number to ascii digits in decimal, octal or hexadecimal
// ----------------------------------------------------------------------------
// usage
//  - slave stream: one request per number, tdata holds the value, tuser the
//    radix select (0 decimal, 1 octal, 2 or 3 hexadecimal)
//  - master stream: one request per digit, most significant first, no
//    leading zeros; tdata carries the ascii code, tlast marks the final digit
//  - a zero value gives a single '0' with tlast set
//  - only the low VALUE_BITS bits of the value take part
//  - a number of d digits is first extracted into the digit store (one divide
//    by the base per cycle) and then emitted from the digit store, most
//    significant digit first
//  - one number at a time: s_axis_tready is low from acceptance until the
//    final digit has been loaded into the output register
//  - a stalled receiver holds the output register and pauses emission
//  - synchronous active-low reset returns to idle with no digit pending
// ----------------------------------------------------------------------------
module radix_digit_emitter_top #(
    parameter int VALUE_BITS = rde_pkg::DEFAULT_VALUE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave request channel
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [rde_pkg::FIELD_BITS-1:0]      i_s_axis_tdata,  // [15:0] value
    input  logic [rde_pkg::RADIX_BITS-1:0]      i_s_axis_tuser,  // [1:0] radix_sel
    // master digit channel
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [rde_pkg::TDATA_OUT_BITS-1:0]  o_m_axis_tdata,  // [6:0] digit_char, [7] zero
    output logic                                o_m_axis_tlast   // last_digit
);
    import rde_pkg::*;

    t_cmd                 w_cmd;
    t_status              w_status;
    logic [CHAR_BITS-1:0] w_char;

    // sequencer
    rde_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    // divider step, digit store and output register
    rde_dp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_s_axis_tdata),
        .i_radix_sel (i_s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_char  (w_char),
        .o_out_last  (o_m_axis_tlast)
    );

    // pad the 7-bit code to a whole byte
    assign o_m_axis_tdata = {{(TDATA_OUT_BITS-CHAR_BITS){1'b0}}, w_char};

endmodule

// File: rtl/core/rde_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rde_checker
// port-level checks on the digit emitter, bound to the top level
// ----------------------------------------------------------------------------
`include "radix_digit_emitter_top_macros.svh"

module rde_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast
);

    // stalled digit holds
    `RDE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))

    // only digit glyphs come out
    `RDE_ASSERT_SAME(a_glyph, i_clk, i_rst_n, o_m_axis_tvalid, (o_m_axis_tdata >= 8'h30 && o_m_axis_tdata <= 8'h39) || (o_m_axis_tdata >= 8'h41 && o_m_axis_tdata <= 8'h46))

    // no new number while a non-final digit is pending
    `RDE_ASSERT_SAME(a_busy_mid, i_clk, i_rst_n, o_m_axis_tvalid && !o_m_axis_tlast, !o_s_axis_tready)

    // busy straight after acceptance
    `RDE_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)

endmodule

bind radix_digit_emitter_top rde_checker u_rde_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

// File: bench/radix_digit_emitter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_emitter_top_test
// self-checking bench for the number to ascii digit converter
// ----------------------------------------------------------------------------
// each accepted number request is expanded into its expected digit requests,
// which are checked in order against the master stream; directed corner
// values come first, then random numbers under random idling on both sides,
// a back-to-back burst, a long receiver hold-off and drain pauses
// ----------------------------------------------------------------------------
module radix_digit_emitter_top_test;

    import rde_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 50;

    typedef struct packed {
        logic [CHAR_BITS-1:0] digit_char;
        logic                 last_digit;
    } t_digit;

    logic                      i_clk           = 1'b0;
    logic                      i_rst_n         = 1'b0;
    logic                      i_s_axis_tvalid = 1'b0;
    logic                      o_s_axis_tready;
    logic [FIELD_BITS-1:0]     i_s_axis_tdata  = '0;  // [15:0] value
    logic [RADIX_BITS-1:0]     i_s_axis_tuser  = '0;  // [1:0] radix_sel
    logic                      o_m_axis_tvalid;
    logic                      i_m_axis_tready = 1'b0;
    logic [TDATA_OUT_BITS-1:0] o_m_axis_tdata;         // [6:0] digit_char, [7] zero
    logic                      o_m_axis_tlast;         // last_digit

    t_digit      pending_digits[$];  // digits still owed by the block, oldest first
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          tx_no_gaps     = 1'b0;
    bit          rx_always_ready = 1'b0;
    int unsigned rx_hold_left   = 0;  // long receiver hold-off, counted below
    int unsigned rx_stall_left  = 0;

    radix_digit_emitter_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // idle run length: mostly short, now and then long
    function automatic int unsigned idle_length(input bit allow_zero);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (allow_zero && roll < 5) return 0;
        if (roll < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // expand one number into its digit requests, most significant first
    task automatic predict_digits(input logic [FIELD_BITS-1:0] value,
                                  input logic [RADIX_BITS-1:0] radix);
        logic [FIELD_BITS-1:0] rest;
        int unsigned           base;
        int unsigned           d;
        t_digit                digits[$];
        t_digit                one;
        case (radix)
            RADIX_DEC: base = 10;
            RADIX_OCT: base = 8;
            default:   base = 16;  // unused code falls back to hex
        endcase
        rest = value;
        // peel digits from the bottom, a zero value still yields one digit
        do begin
            d = rest % base;
            one.digit_char = (d < 10) ? CHAR_BITS'(8'h30 + d) : CHAR_BITS'(8'h41 + d - 10);
            one.last_digit = 1'b0;
            digits.push_front(one);
            rest = rest / base;
        end while (rest != 0);
        digits[digits.size() - 1].last_digit = 1'b1;
        foreach (digits[k]) pending_digits.push_back(digits[k]);
    endtask

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("mismatch at %0t ns: %s expected %0h got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    // output check first, then prediction, so a digit never meets its own number
    always @(posedge i_clk) begin
        t_digit want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_digits.size() == 0) begin
                report_mismatch("unexpected digit", 0, o_m_axis_tdata);
            end else begin
                want = pending_digits.pop_front();
                if (o_m_axis_tdata[CHAR_BITS-1:0] !== want.digit_char)
                    report_mismatch("digit_char", want.digit_char,
                                    o_m_axis_tdata[CHAR_BITS-1:0]);
                if (o_m_axis_tlast !== want.last_digit)
                    report_mismatch("last_digit", want.last_digit, o_m_axis_tlast);
            end
        end
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            predict_digits(i_s_axis_tdata, i_s_axis_tuser);
    end

    // receiver: long hold-off when asked, otherwise random stalls
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (rx_stall_left != 0) begin
                rx_stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!rx_always_ready && $urandom_range(0, 3) == 0)
                    rx_stall_left = idle_length(1'b0);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // offer one number request and wait for it to be taken; valid stays high
    // when no gap follows so the next request can go straight out
    task automatic send_number(input logic [FIELD_BITS-1:0] value,
                               input logic [RADIX_BITS-1:0] radix);
        int unsigned gap;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tuser  <= radix;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        gap = tx_no_gaps ? 0 : idle_length(1'b1);
        if (gap != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic end_burst();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_digits.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [FIELD_BITS-1:0] random_value();
        // shifting spreads the digit counts, so short numbers turn up often
        return FIELD_BITS'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    endfunction

    // corner values in every radix code, including the unused one
    task automatic test_corner_values();
        logic [RADIX_BITS-1:0] r;
        for (int i = 0; i < 4; i++) begin
            r = RADIX_BITS'(i);
            send_number(16'd0, r);
            send_number(16'hFFFF, r);
        end
        send_number(16'd9, RADIX_DEC);
        send_number(16'd10, RADIX_DEC);
        send_number(16'd42, RADIX_DEC);
        send_number(16'd7, RADIX_OCT);
        send_number(16'd8, RADIX_OCT);
        send_number(16'h8000, RADIX_OCT);
        send_number(16'h000F, RADIX_HEX);
        send_number(16'h0010, RADIX_HEX);
        send_number(16'hABCD, RADIX_HEX);
        send_number(16'h1234, RADIX_SPARE);
        send_number(16'h5A5A, RADIX_DEC);
        end_burst();
        wait_drained();
    endtask

    // random numbers and radix codes, pausing for a full drain now and then
    task automatic test_random_numbers(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            if (i % 18 == 17) begin
                end_burst();
                wait_drained();
            end
            send_number(random_value(), RADIX_BITS'($urandom_range(0, 3)));
        end
        end_burst();
        wait_drained();
    endtask

    // no idling on either side
    task automatic test_back_to_back(input int unsigned count);
        tx_no_gaps      = 1'b1;
        rx_always_ready = 1'b1;
        for (int unsigned i = 0; i < count; i++)
            send_number(random_value(), RADIX_BITS'($urandom_range(0, 3)));
        end_burst();
        wait_drained();
        tx_no_gaps      = 1'b0;
        rx_always_ready = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering, input must stall
    task automatic test_receiver_holdoff(input int unsigned count);
        tx_no_gaps   = 1'b1;
        rx_hold_left = 300;
        for (int unsigned i = 0; i < count; i++)
            send_number(random_value(), RADIX_BITS'($urandom_range(0, 3)));
        end_burst();
        wait_drained();
        tx_no_gaps = 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_corner_values();
        test_random_numbers(56);
        test_back_to_back(25);
        test_receiver_holdoff(10);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_digits.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
